@@ design/shs_pkg.sv @@
// ----------------------------------------------------------------------------
// Smoothed Heaviside stencil package
// Shared request types, fixed-point constants and control codes.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [16:0] ONE_FX  = 17'(1) << FRAC_BITS;
  localparam logic [16:0] HALF_FX = 17'(1) << (FRAC_BITS - 1);

  // Divider geometry: remainder as wide as the divisor, up to 31 quotient bits.
  localparam int DEN_W     = 48;
  localparam int DIV_LOW_W = 31;
  localparam logic [4:0] H_DIV_STEPS = 5'(FRAC_BITS + 2);
  localparam logic [4:0] D_DIV_STEPS = 5'(DIV_LOW_W);

  // Configuration register indexes.
  localparam logic [1:0] CFG_GRID_SPACING    = 2'd0;
  localparam logic [1:0] CFG_INV_TWO_H       = 2'd1;
  localparam logic [1:0] CFG_HALF_H_SQUARED  = 2'd2;
  localparam logic [1:0] CFG_DELTA_THRESHOLD = 2'd3;

  typedef struct packed {
    logic signed [31:0] sdf_center;
    logic signed [31:0] dist_plus_x;
    logic signed [31:0] dist_minus_x;
    logic signed [31:0] dist_plus_y;
    logic signed [31:0] dist_minus_y;
    logic signed [31:0] dist_plus_z;
    logic signed [31:0] dist_minus_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [16:0] fluid_chi_in;
    logic               last_cell;
  } shs_in_t;

  typedef struct packed {
    logic        [16:0] obstacle_chi;
    logic        [16:0] fluid_chi_out;
    logic signed [31:0] surface_delta;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic               surface_hit;
    logic        [46:0] mass_total;
    logic signed [47:0] moment_x;
    logic signed [47:0] moment_y;
    logic signed [47:0] moment_z;
    logic               block_done;
  } shs_out_t;

  typedef struct packed {
    logic [30:0] grid_spacing;
    logic [30:0] inv_two_h;
    logic [30:0] half_h_squared;
    logic [30:0] delta_threshold;
  } shs_cfg_t;

  // A classified cell waiting for the back end.
  typedef struct packed {
    shs_in_t req;
    logic    far;
  } shs_job_t;

  typedef struct packed {
    logic                 start;
    logic [DEN_W-1:0]     rem;
    logic [DIV_LOW_W-1:0] low;
    logic [4:0]           steps;
    logic [DEN_W-1:0]     den;
  } shs_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_LOW_W-1:0] quot;
  } shs_div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIVH,
    ST_WAITH,
    ST_DIVD,
    ST_WAITD,
    ST_OUT
  } shs_state_e;

  typedef enum logic [3:0] {
    OP_G,
    OP_GP,
    OP_SQ,
    OP_NH,
    OP_ND,
    OP_DELTA,
    OP_MX,
    OP_MY,
    OP_MZ
  } shs_op_e;

endpackage

@@ design/shs_front.sv @@
// ----------------------------------------------------------------------------
// Smoothed Heaviside stencil front end
// Accepts cell requests, marks far cells and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module shs_front import shs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  shs_in_t  in_req_i,
  input  logic [31:0] two_h_i,
  output logic     job_valid_o,
  output shs_job_t job_o,
  input  logic     job_take_i
);

  shs_job_t    fifo_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  logic signed [33:0] d0, lim;
  shs_job_t    job_in;

  // A cell is far when its centre distance lies outside [-2h, 2h].
  assign d0  = {{2{in_req_i.sdf_center[31]}}, in_req_i.sdf_center};
  assign lim = {2'b00, two_h_i};

  always_comb begin
    job_in.req = in_req_i;
    job_in.far = (d0 > lim) || (d0 < -lim);
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = fifo_q[rptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = job_take_i && job_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= job_in;
  end

endmodule

@@ design/shs_div.sv @@
// ----------------------------------------------------------------------------
// Smoothed Heaviside stencil divider
// Restoring divider, one quotient bit per cycle, up to 31 bits.
// ----------------------------------------------------------------------------
module shs_div import shs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  shs_div_req_t req_i,
  output shs_div_rsp_t rsp_o
);

  logic [DEN_W-1:0]     rem_q, den_q;
  logic [DIV_LOW_W-1:0] low_q, quot_q;
  logic [4:0]           cnt_q;
  logic                 busy_q, done_q;
  logic [DEN_W:0]       r2;
  logic                 ge;

  // The caller guarantees the starting remainder is below the divisor.
  assign r2 = {rem_q, low_q[DIV_LOW_W-1]};
  assign ge = r2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem;
      low_q  <= req_i.low;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? DEN_W'(r2 - {1'b0, den_q}) : r2[DEN_W-1:0];
      low_q  <= low_q << 1;
      quot_q <= {quot_q[DIV_LOW_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

@@ design/shs_back.sv @@
// ----------------------------------------------------------------------------
// Smoothed Heaviside stencil back end
// Sequencer around one shared multiplier and the divider; keeps the sums.
// ----------------------------------------------------------------------------
module shs_back import shs_pkg::*; #(
  parameter int ACC_WIDTH = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  shs_cfg_t     cfg_i,
  input  logic         job_valid_i,
  input  shs_job_t     job_i,
  output logic         job_take_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output shs_out_t     out_req_o,
  output shs_div_req_t div_req_o,
  input  shs_div_rsp_t div_rsp_i
);

  localparam logic signed [67:0] SAT_HI = 68'sh7FFFFFFF;
  localparam logic signed [67:0] SAT_LO = -68'sh80000000;

  shs_state_e state_q, state_d;
  shs_op_e    op_q;
  logic [1:0] axis_q;
  shs_job_t   job_q;

  logic signed [67:0] prod_q;
  logic signed [31:0] g_q [3];
  logic signed [31:0] gp_q;
  logic        [63:0] sq_q;
  logic signed [49:0] num_h_q;
  logic signed [33:0] num_d_q;
  logic        [63:0] dprod_q;
  logic        [16:0] h_q;
  logic        [31:0] mag_q;
  logic signed [32:0] mom_q [3];

  logic [ACC_WIDTH-1:0] mass_acc_q;
  logic [ACC_WIDTH-1:0] mom_acc_q [3];
  shs_out_t out_q;
  logic     out_valid_q;

  logic signed [31:0] nb_p, nb_m, nb_pp, nb_mp, g_cur;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] fs;
  logic signed [31:0] fs_sat;
  logic [DEN_W-1:0]   den;
  logic [49:0]        h_rem0;
  logic               h_pos, h_sat, d_sat, out_free;
  logic [32:0]        d_rem0;
  logic [16:0]        h_div;
  logic signed [31:0] delta;
  logic               hit;
  logic [ACC_WIDTH-1:0] mass_new;
  logic [ACC_WIDTH-1:0] mom_new [3];
  logic [63:0]        mass_ext;
  logic [63:0]        mom_ext [3];
  shs_out_t           out_d;

  function automatic logic signed [17:0] step_val(input logic signed [31:0] d);
    logic signed [17:0] v;
    if (d == 32'sd0) v = $signed({1'b0, HALF_FX});
    else if (d < 32'sd0) v = 18'sd0;
    else v = $signed({1'b0, ONE_FX});
    return v;
  endfunction

  function automatic logic signed [31:0] pos_part(input logic signed [31:0] d);
    return (d < 32'sd0) ? 32'sd0 : d;
  endfunction

  // Neighbor pair for the axis being worked on.
  always_comb begin
    case (axis_q)
      2'd0: begin
        nb_p = job_q.req.dist_plus_x;
        nb_m = job_q.req.dist_minus_x;
      end
      2'd1: begin
        nb_p = job_q.req.dist_plus_y;
        nb_m = job_q.req.dist_minus_y;
      end
      default: begin
        nb_p = job_q.req.dist_plus_z;
        nb_m = job_q.req.dist_minus_z;
      end
    endcase
  end

  assign nb_pp = pos_part(nb_p);
  assign nb_mp = pos_part(nb_m);
  assign g_cur = g_q[axis_q];

  // Operand selection for the shared multiplier.
  always_comb begin
    case (op_q)
      OP_G: begin
        mul_a = $signed({3'b000, cfg_i.inv_two_h});
        mul_b = {{2{nb_p[31]}}, nb_p} - {{2{nb_m[31]}}, nb_m};
      end
      OP_GP: begin
        mul_a = $signed({3'b000, cfg_i.inv_two_h});
        mul_b = {{2{nb_pp[31]}}, nb_pp} - {{2{nb_mp[31]}}, nb_mp};
      end
      OP_SQ: begin
        mul_a = {{2{g_cur[31]}}, g_cur};
        mul_b = {{2{g_cur[31]}}, g_cur};
      end
      OP_NH: begin
        mul_a = {{2{gp_q[31]}}, gp_q};
        mul_b = {{2{g_cur[31]}}, g_cur};
      end
      OP_ND: begin
        mul_a = 34'(step_val(nb_p) - step_val(nb_m));
        mul_b = {{2{g_cur[31]}}, g_cur};
      end
      OP_DELTA: begin
        mul_a = $signed({3'b000, cfg_i.half_h_squared});
        mul_b = (num_d_q < 34'sd0) ? -num_d_q : num_d_q;
      end
      OP_MX: begin
        mul_a = {{2{job_q.req.pos_x[31]}}, job_q.req.pos_x};
        mul_b = $signed({17'b0, h_q});
      end
      OP_MY: begin
        mul_a = {{2{job_q.req.pos_y[31]}}, job_q.req.pos_y};
        mul_b = $signed({17'b0, h_q});
      end
      OP_MZ: begin
        mul_a = {{2{job_q.req.pos_z[31]}}, job_q.req.pos_z};
        mul_b = $signed({17'b0, h_q});
      end
      default: begin
        mul_a = 34'sd0;
        mul_b = 34'sd0;
      end
    endcase
  end

  // Floor shift of the registered product and its 32-bit saturation.
  assign fs = prod_q >>> FRAC_BITS;
  always_comb begin
    if (fs > SAT_HI) fs_sat = 32'sh7FFFFFFF;
    else if (fs < SAT_LO) fs_sat = 32'sh80000000;
    else fs_sat = fs[31:0];
  end

  assign den    = sq_q[63:FRAC_BITS] + DEN_W'(1);
  assign h_pos  = num_h_q > 50'sd0;
  assign h_rem0 = 50'(num_h_q >>> 2);
  assign h_sat  = h_rem0 >= {2'b00, den};
  assign d_rem0 = dprod_q[63:DIV_LOW_W];
  assign d_sat  = {15'b0, d_rem0} >= den;
  assign h_div  = (div_rsp_i.quot > 31'(ONE_FX)) ? ONE_FX : div_rsp_i.quot[16:0];
  assign out_free = !out_valid_q || !out_stall_i;

  // Final delta: sign from the numerator, magnitude already clamped to 2^31.
  always_comb begin
    if (num_d_q < 34'sd0) delta = $signed(32'(-mag_q));
    else if (mag_q[31]) delta = 32'sh7FFFFFFF;
    else delta = $signed(mag_q);
    hit = $signed({delta[31], delta}) > $signed({2'b00, cfg_i.delta_threshold});
  end

  // Result assembly and running sums.
  always_comb begin
    mass_new = mass_acc_q + ACC_WIDTH'(h_q);
    mass_ext = 64'(mass_new);
    for (int i = 0; i < 3; i++) begin
      mom_new[i] = mom_acc_q[i] + {{(ACC_WIDTH-33){mom_q[i][32]}}, mom_q[i]};
      mom_ext[i] = 64'(mom_new[i]);
    end
    out_d.obstacle_chi  = h_q;
    out_d.fluid_chi_out = (job_q.req.fluid_chi_in > h_q) ? job_q.req.fluid_chi_in : h_q;
    out_d.surface_delta = delta;
    out_d.grad_x        = g_q[0];
    out_d.grad_y        = g_q[1];
    out_d.grad_z        = g_q[2];
    out_d.surface_hit   = hit;
    if (job_q.req.last_cell) begin
      out_d.mass_total = mass_ext[46:0];
      out_d.moment_x   = $signed(mom_ext[0][47:0]);
      out_d.moment_y   = $signed(mom_ext[1][47:0]);
      out_d.moment_z   = $signed(mom_ext[2][47:0]);
      out_d.block_done = 1'b1;
    end else begin
      out_d.mass_total = '0;
      out_d.moment_x   = '0;
      out_d.moment_y   = '0;
      out_d.moment_z   = '0;
      out_d.block_done = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (job_valid_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC: begin
        if (op_q == OP_DELTA) state_d = ST_DIVH;
        else if (op_q == OP_MZ) state_d = ST_OUT;
        else state_d = ST_MUL;
      end
      ST_DIVH:  state_d = (!h_pos || h_sat) ? ST_DIVD : ST_WAITH;
      ST_WAITH: if (div_rsp_i.done) state_d = ST_DIVD;
      ST_DIVD:  state_d = d_sat ? ST_MUL : ST_WAITD;
      ST_WAITD: if (div_rsp_i.done) state_d = ST_MUL;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    job_take_o      = (state_q == ST_IDLE) && job_valid_i;
    div_req_o.start = 1'b0;
    div_req_o.rem   = DEN_W'(h_rem0);
    div_req_o.low   = {num_h_q[1:0], {(DIV_LOW_W-2){1'b0}}};
    div_req_o.steps = H_DIV_STEPS;
    div_req_o.den   = den;
    case (state_q)
      ST_DIVH: div_req_o.start = h_pos && !h_sat;
      ST_DIVD: begin
        div_req_o.start = !d_sat;
        div_req_o.rem   = DEN_W'(d_rem0);
        div_req_o.low   = dprod_q[DIV_LOW_W-1:0];
        div_req_o.steps = D_DIV_STEPS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_G;
      axis_q      <= 2'd0;
      out_valid_q <= 1'b0;
      mass_acc_q  <= '0;
      for (int i = 0; i < 3; i++) mom_acc_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_OUT) && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            op_q   <= job_i.far ? OP_MX : OP_G;
            axis_q <= 2'd0;
          end
        end
        ST_ACC: begin
          case (op_q)
            OP_G:  op_q <= OP_GP;
            OP_GP: op_q <= OP_SQ;
            OP_SQ: op_q <= OP_NH;
            OP_NH: op_q <= OP_ND;
            OP_ND: begin
              if (axis_q == 2'd2) begin
                op_q <= OP_DELTA;
              end else begin
                axis_q <= axis_q + 2'd1;
                op_q   <= OP_G;
              end
            end
            OP_MX: op_q <= OP_MY;
            OP_MY: op_q <= OP_MZ;
            default: ;
          endcase
        end
        ST_DIVH: op_q <= OP_MX;
        ST_OUT: begin
          if (out_free) begin
            if (job_q.req.last_cell) begin
              mass_acc_q <= '0;
              for (int i = 0; i < 3; i++) mom_acc_q[i] <= '0;
            end else begin
              mass_acc_q <= mass_new;
              for (int i = 0; i < 3; i++) mom_acc_q[i] <= mom_new[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_q   <= job_i;
          sq_q    <= '0;
          num_h_q <= '0;
          num_d_q <= '0;
          mag_q   <= '0;
          for (int i = 0; i < 3; i++) g_q[i] <= '0;
          h_q <= (job_i.req.sdf_center > 32'sd0) ? ONE_FX : 17'd0;
        end
      end
      ST_MUL: prod_q <= mul_a * mul_b;
      ST_ACC: begin
        case (op_q)
          OP_G:     g_q[axis_q] <= fs_sat;
          OP_GP:    gp_q <= fs_sat;
          OP_SQ:    sq_q <= sq_q + prod_q[63:0];
          OP_NH:    num_h_q <= num_h_q + fs[49:0];
          OP_ND:    num_d_q <= num_d_q + fs[33:0];
          OP_DELTA: dprod_q <= prod_q[63:0];
          OP_MX:    mom_q[0] <= fs[32:0];
          OP_MY:    mom_q[1] <= fs[32:0];
          OP_MZ:    mom_q[2] <= fs[32:0];
          default: ;
        endcase
      end
      ST_DIVH: begin
        if (!h_pos) h_q <= 17'd0;
        else if (h_sat) h_q <= ONE_FX;
      end
      ST_WAITH: if (div_rsp_i.done) h_q <= h_div;
      ST_DIVD:  if (d_sat) mag_q <= 32'h80000000;
      ST_WAITD: if (div_rsp_i.done) mag_q <= {1'b0, div_rsp_i.quot};
      ST_OUT:   if (out_free) out_q <= out_d;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

@@ design/smoothed_heaviside_stencil_core.sv @@
// ----------------------------------------------------------------------------
// Smoothed Heaviside stencil core
// Per-cell obstacle indicator, surface delta and mass/moment sums.
// ----------------------------------------------------------------------------
// Each request carries one grid cell: the signed distance at its centre and
// six face neighbors, its position and the fluid's chi. The front end takes
// requests into a two-entry queue and marks cells farther than two spacings
// from the surface; the back end works on one cell at a time with a single
// shared multiplier (a product takes ST_MUL, then ST_ACC) and a bit-per-cycle
// divider. A far cell needs only three moment multiplies; a near cell needs 16
// multiplies for gradients, dot products and delta, an 18-step division for
// the Heaviside value, a 31-step division for the delta and three moment
// multiplies. A finished result waits in the output register while the next
// cell is taken in. The mass and moment sums include the cell that carries
// last_cell, appear on that result only, and are cleared after it. Write the
// configuration registers only while no cell is in flight; nothing enforces it.
// ----------------------------------------------------------------------------
module smoothed_heaviside_stencil_core import shs_pkg::*; #(
  parameter int ACC_WIDTH = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  shs_in_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output shs_out_t    out_req_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i
);

  shs_cfg_t     cfg_q;
  logic         job_valid, job_take;
  shs_job_t     job;
  shs_div_req_t div_req;
  shs_div_rsp_t div_rsp;

  // Configuration registers, reset to a unit spacing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_spacing    <= 31'd65536;
      cfg_q.inv_two_h       <= 31'd32768;
      cfg_q.half_h_squared  <= 31'd32768;
      cfg_q.delta_threshold <= 31'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_SPACING:    cfg_q.grid_spacing    <= cfg_data_i;
        CFG_INV_TWO_H:       cfg_q.inv_two_h       <= cfg_data_i;
        CFG_HALF_H_SQUARED:  cfg_q.half_h_squared  <= cfg_data_i;
        CFG_DELTA_THRESHOLD: cfg_q.delta_threshold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The far test compares against twice the spacing.
  shs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .two_h_i     ({cfg_q.grid_spacing, 1'b0}),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_take_i  (job_take)
  );

  shs_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_take_o  (job_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  shs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

@@ design/shs_checker.sv @@
// ----------------------------------------------------------------------------
// Smoothed Heaviside stencil checker
// Port-level properties of the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module shs_checker import shs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input shs_out_t out_req_o
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // Sums are shown only on the last cell of a block.
  a_sums_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.block_done |->
      out_req_o.mass_total == '0 && out_req_o.moment_x == '0 &&
      out_req_o.moment_y == '0 && out_req_o.moment_z == '0)
    else $error("sums outside block end");

  // The indicator is clamped and the fluid chi never drops below it.
  a_chi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_req_o.obstacle_chi <= ONE_FX &&
      out_req_o.fluid_chi_out >= out_req_o.obstacle_chi)
    else $error("chi out of range");

  // A surface cell needs a positive delta.
  a_hit_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.surface_hit |-> out_req_o.surface_delta > 32'sd0)
    else $error("surface flag without positive delta");

endmodule

bind smoothed_heaviside_stencil_core shs_checker u_shs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);
